>>> rtl/pfsr_pkg.sv
package pfsr_pkg;

    localparam logic [9:0]  SPEED_LIMIT       = 10'd1000;
    localparam logic [7:0]  TOLERANCE_RESET   = 8'd5;
    localparam logic [15:0] FAULT_DELAY_RESET = 16'd5000;

    // floor(v/3) = (v * RECIP3) >> RECIP3_SHIFT, exact for v < 2048
    localparam int          RECIP3_SHIFT      = 11;
    localparam logic [9:0]  RECIP3            = 10'd683;

    typedef enum logic {
        OP_REGULATE = 1'b0,
        OP_LOAD     = 1'b1
    } t_op;

    typedef enum logic {
        CFG_TOLERANCE   = 1'b0,
        CFG_FAULT_DELAY = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  tolerance;
        logic [15:0] fault_delay_ms;
    } t_cfg;

    typedef struct packed {
        logic [9:0]  fan_speed;
        logic        fault;
        logic [31:0] last_in_band;
    } t_state;

endpackage

>>> rtl/pfsr_cfg.sv
module pfsr_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [0:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output pfsr_pkg::t_cfg o_cfg
);
    import pfsr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TOLERANCE:   n_cfg.tolerance      = i_cfg_data[7:0];
                CFG_FAULT_DELAY: n_cfg.fault_delay_ms = i_cfg_data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tolerance      <= TOLERANCE_RESET;
            r_cfg.fault_delay_ms <= FAULT_DELAY_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> rtl/pfsr_law.sv
module pfsr_law (
    input  pfsr_pkg::t_cfg   i_cfg,
    input  pfsr_pkg::t_state i_state,
    input  logic             i_opcode,
    input  logic [7:0]       i_target_pressure,
    input  logic [9:0]       i_measured_pressure,
    input  logic [31:0]      i_now_ms,
    input  logic [15:0]      i_set_value,
    output pfsr_pkg::t_state o_state,
    output logic             o_in_band
);
    import pfsr_pkg::*;

    logic signed [10:0] err;
    logic        [9:0]  mag;
    logic        [10:0] twice;
    logic        [10:0] div_in;
    logic        [20:0] prod;
    logic        [9:0]  step;
    logic signed [11:0] sum;
    logic        [31:0] elapsed;
    logic               band;

    assign err = $signed({3'b000, i_target_pressure})
               - $signed({i_measured_pressure[9], i_measured_pressure});
    assign mag = err[10] ? 10'((-err)) : err[9:0];

    // floor((10*speed + trunc(err*20/3)) / 10) reduces to speed + floor(2*err/3);
    // for negative err the step is -ceil(2|err|/3)
    assign twice  = {mag, 1'b0};
    assign div_in = err[10] ? twice + 11'd2 : twice;
    assign prod   = div_in * RECIP3;
    assign step   = prod[20:RECIP3_SHIFT];
    assign sum    = err[10] ? $signed({2'b00, i_state.fan_speed}) - $signed({2'b00, step})
                            : $signed({2'b00, i_state.fan_speed}) + $signed({2'b00, step});

    assign elapsed = i_now_ms - i_state.last_in_band;
    assign band    = ({2'b00, i_cfg.tolerance} > mag);

    always_comb begin
        o_state   = i_state;
        o_in_band = 1'b0;
        case (t_op'(i_opcode))
            OP_LOAD: begin
                o_state.fan_speed = (i_set_value > {6'd0, SPEED_LIMIT}) ? SPEED_LIMIT
                                                                       : i_set_value[9:0];
            end
            default: begin
                if (band) begin
                    o_in_band            = 1'b1;
                    o_state.fault        = 1'b0;
                    o_state.last_in_band = i_now_ms;
                end else begin
                    if (elapsed > {16'd0, i_cfg.fault_delay_ms}) begin
                        o_state.fault = 1'b1;
                    end
                    if (sum[11]) begin
                        o_state.fan_speed = '0;
                    end else if (sum > $signed({2'b00, SPEED_LIMIT})) begin
                        o_state.fan_speed = SPEED_LIMIT;
                    end else begin
                        o_state.fan_speed = sum[9:0];
                    end
                end
            end
        endcase
    end

endmodule

>>> rtl/pressure_fan_speed_regulator.sv
// Proportional fan-speed regulator with a deadband and a fault timer. Opcode 0
// regulates from a pressure sample: inside the deadband the speed holds, the fault
// clears and the time is stamped; outside it the speed moves by 2/3 of the error
// (clamped to 0..1000) and the fault sets once the wrapped time since the last
// in-band sample exceeds fault_delay_ms. Opcode 1 loads the speed, saturated at
// 1000. Throughput is one item per clock while the output is not stalled. Each item
// passes through the input register, then the result register, which loads together
// with the speed, fault and timestamp state. While the result waits, one more item is
// held in the input register and the input stalls behind it. Configuration writes are
// always accepted and should only be made while the block is idle.
module pressure_fan_speed_regulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_target_pressure,
    input  logic [9:0]  i_measured_pressure,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_set_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [9:0]  o_drive_speed,
    output logic        o_fault,
    output logic        o_in_band
);
    import pfsr_pkg::*;

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;
    logic   band;
    logic   advance;

    logic        r_s1_valid;
    logic        r_opcode;
    logic [7:0]  r_target;
    logic [9:0]  r_measured;
    logic [31:0] r_now;
    logic [15:0] r_set;

    logic        r_out_valid;
    logic [9:0]  r_speed;
    logic        r_fault;
    logic        r_band;

    pfsr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pfsr_law u_law (
        .i_cfg               (cfg),
        .i_state             (r_state),
        .i_opcode            (r_opcode),
        .i_target_pressure   (r_target),
        .i_measured_pressure (r_measured),
        .i_now_ms            (r_now),
        .i_set_value         (r_set),
        .o_state             (n_state),
        .o_in_band           (band)
    );

    // stage 1 item moves on when the result register is free or being drained
    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;

    assign o_out_valid   = r_out_valid;
    assign o_drive_speed = r_speed;
    assign o_fault       = r_fault;
    assign o_in_band     = r_band;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_opcode   <= i_opcode;
            r_target   <= i_target_pressure;
            r_measured <= i_measured_pressure;
            r_now      <= i_now_ms;
            r_set      <= i_set_value;
        end
        if (advance) begin
            r_speed <= n_state.fan_speed;
            r_fault <= n_state.fault;
            r_band  <= band;
        end
    end

endmodule
